FILE: rtl/hsl_pkg.sv
// shared types and constants for the hsl to rgb converter
package hsl_pkg;

  // input and result field widths
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned FRAC_W  = 13;
  localparam int unsigned CHAN_W  = 8;

  // internal widths
  localparam int unsigned WGT_W   = 12;  // secondary weight, 0..3840
  localparam int unsigned CHROMA_W = 25; // chroma in q24, 0..2^24
  localparam int unsigned NUM_W   = 37;  // channel numerator over 15 * 2^32

  // fixed-point constants
  localparam logic [FRAC_W-1:0]   ONE_Q12      = 13'd4096;
  localparam logic [WGT_W-1:0]    SECTOR_W12   = 12'd3840;
  localparam logic [CHROMA_W-1:0] ONE_Q24      = 25'd16777216;
  localparam logic [HUE_W-1:0]    SECTOR_Q6    = 15'd3840;
  localparam logic [HUE_W-1:0]    SECTOR2_Q6   = 15'd7680;
  localparam logic [HUE_W-1:0]    SECTOR3_Q6   = 15'd11520;
  localparam logic [HUE_W-1:0]    SECTOR4_Q6   = 15'd15360;
  localparam logic [HUE_W-1:0]    SECTOR5_Q6   = 15'd19200;
  localparam logic [HUE_W-1:0]    FULL_TURN_Q6 = 15'd23040;

  // rounding and the divide by 15 after the shift by 32
  localparam logic [44:0] HALF_DEN   = 45'd32212254720;  // 15 * 2^31
  localparam logic [16:0] RECIP_15   = 17'd69906;        // ceil(2^20 / 15)
  localparam int unsigned RECIP_SH   = 20;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // 60-degree hue sector, gray for hue at or above a full turn
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5,
    SEC_GRAY    = 3'd6
  } sector_t;

endpackage

FILE: rtl/hsl_chan_scale.sv
// two-stage scale of one channel numerator to 8 bits with round and clamp
module hsl_chan_scale (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hsl_pkg::NUM_W-1:0]  num,
  output logic [hsl_pkg::CHAN_W-1:0] chan
);
  import hsl_pkg::*;

  logic [44:0]         scaled;
  logic [12:0]         tq_r;
  logic [29:0]         prod;
  logic [9:0]          quot;
  logic [CHAN_W-1:0]   chan_r;
  logic [CHAN_W-1:0]   chan_nxt;

  // 255 * n plus half the denominator, keep bits above 2^32
  assign scaled = ({8'b0, num} << 8) - {8'b0, num} + HALF_DEN;

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r <= scaled[44:32];
    end
  end

  // divide by 15 through the reciprocal, exact for this range
  assign prod = 30'(tq_r) * 30'(RECIP_15);
  assign quot = prod[29:RECIP_SH];

  // clamp to the channel range
  always_comb begin
    if (quot > 10'(CHAN_MAX)) begin
      chan_nxt = CHAN_MAX;
    end else begin
      chan_nxt = quot[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

`ifndef SYNTH
  // rounded quotient never exceeds full scale for in-range numerators
  a_quot_range: assert property (@(posedge clk)
    (num <= 37'd64424509440) |=> ($past(en) == 1'b0 || tq_r <= 13'd3832))
    else $error("scaled channel out of range");
`endif

endmodule

FILE: rtl/hsl_to_rgb.sv
// hsl to rgb converter, six-stage pipeline with three channel scalers
// six register stages lie between input transfer and result valid
// throughput: one pixel per cycle while no finished result is held; all stages advance together
// a stalled output holds the whole pipeline and in_stall follows it
// reset: synchronous active-low rst_n clears the stage valid bits only
module hsl_to_rgb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hsl_pkg::HUE_W-1:0]    in_hue_q6,
  input  logic [hsl_pkg::FRAC_W-1:0]   in_sat_q12,
  input  logic [hsl_pkg::FRAC_W-1:0]   in_light_q12,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hsl_pkg::CHAN_W-1:0]   out_red,
  output logic [hsl_pkg::CHAN_W-1:0]   out_green,
  output logic [hsl_pkg::CHAN_W-1:0]   out_blue
);
  import hsl_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1 signals
  logic [FRAC_W-1:0]  sat_c, light_c;
  logic [FRAC_W:0]    dbl, dev;
  logic [FRAC_W-1:0]  a_nxt;
  sector_t            sec_nxt;
  logic [HUE_W-1:0]   base, off;
  logic [WGT_W-1:0]   w_nxt;
  sector_t            sec1_r;
  logic [WGT_W-1:0]   w1_r;
  logic [FRAC_W-1:0]  a1_r, sat1_r, light1_r;

  // stage 2 signals
  logic [25:0]          c_prod;
  logic [CHROMA_W-1:0]  c2_r;
  sector_t              sec2_r;
  logic [WGT_W-1:0]     w2_r;
  logic [FRAC_W-1:0]    light2_r;

  // stage 3 signals
  logic [NUM_W-1:0] cn_nxt, xn_nxt, lt, ch, mn_nxt;
  logic [NUM_W-1:0] cn3_r, xn3_r, mn3_r;
  sector_t          sec3_r;

  // stage 4 signals
  logic [NUM_W-1:0] r_comp, g_comp, b_comp;
  logic [NUM_W-1:0] n_red_r, n_green_r, n_blue_r;

  // whole pipeline moves unless a finished result is held
  assign en       = !(v6_r && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // stage 1: saturate inputs, 1 - |2l - 1|, hue sector and weight
  always_comb begin
    sat_c   = (in_sat_q12 > ONE_Q12) ? ONE_Q12 : in_sat_q12;
    light_c = (in_light_q12 > ONE_Q12) ? ONE_Q12 : in_light_q12;
    dbl     = {light_c, 1'b0};
    if (dbl >= {1'b0, ONE_Q12}) begin
      dev = dbl - {1'b0, ONE_Q12};
    end else begin
      dev = {1'b0, ONE_Q12} - dbl;
    end
    a_nxt = FRAC_W'({1'b0, ONE_Q12} - dev);

    if (in_hue_q6 < SECTOR_Q6) begin
      sec_nxt = SEC_RED_YEL;
    end else if (in_hue_q6 < SECTOR2_Q6) begin
      sec_nxt = SEC_YEL_GRN;
    end else if (in_hue_q6 < SECTOR3_Q6) begin
      sec_nxt = SEC_GRN_CYN;
    end else if (in_hue_q6 < SECTOR4_Q6) begin
      sec_nxt = SEC_CYN_BLU;
    end else if (in_hue_q6 < SECTOR5_Q6) begin
      sec_nxt = SEC_BLU_MAG;
    end else if (in_hue_q6 < FULL_TURN_Q6) begin
      sec_nxt = SEC_MAG_RED;
    end else begin
      sec_nxt = SEC_GRAY;
    end

    unique case (sec_nxt)
      SEC_RED_YEL: base = '0;
      SEC_YEL_GRN: base = SECTOR_Q6;
      SEC_GRN_CYN: base = SECTOR2_Q6;
      SEC_CYN_BLU: base = SECTOR3_Q6;
      SEC_BLU_MAG: base = SECTOR4_Q6;
      SEC_MAG_RED: base = SECTOR5_Q6;
      default:     base = in_hue_q6;
    endcase
    off = in_hue_q6 - base;

    // rising weight in even sectors, falling in odd ones
    case (sec_nxt) inside
      SEC_YEL_GRN, SEC_CYN_BLU, SEC_MAG_RED: w_nxt = SECTOR_W12 - off[WGT_W-1:0];
      SEC_GRAY:                              w_nxt = '0;
      default:                               w_nxt = off[WGT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec1_r   <= sec_nxt;
      w1_r     <= w_nxt;
      a1_r     <= a_nxt;
      sat1_r   <= sat_c;
      light1_r <= light_c;
    end
  end

  // stage 2: chroma in q24
  assign c_prod = 26'(a1_r) * 26'(sat1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r     <= c_prod[CHROMA_W-1:0];
      sec2_r   <= sec1_r;
      w2_r     <= w1_r;
      light2_r <= light1_r;
    end
  end

  // stage 3: chroma, secondary and offset numerators
  always_comb begin
    cn_nxt = (NUM_W'(c2_r) << 12) - (NUM_W'(c2_r) << 8);
    xn_nxt = NUM_W'(c2_r) * NUM_W'(w2_r);
    lt     = (NUM_W'(light2_r) << 24) - (NUM_W'(light2_r) << 20);
    ch     = (NUM_W'(c2_r) << 11) - (NUM_W'(c2_r) << 7);
    mn_nxt = lt - ch;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cn3_r  <= cn_nxt;
      xn3_r  <= xn_nxt;
      mn3_r  <= mn_nxt;
      sec3_r <= sec2_r;
    end
  end

  // stage 4: route components by sector and add the offset
  always_comb begin
    r_comp = '0;
    g_comp = '0;
    b_comp = '0;
    unique case (sec3_r)
      SEC_RED_YEL: begin
        r_comp = cn3_r;
        g_comp = xn3_r;
      end
      SEC_YEL_GRN: begin
        r_comp = xn3_r;
        g_comp = cn3_r;
      end
      SEC_GRN_CYN: begin
        g_comp = cn3_r;
        b_comp = xn3_r;
      end
      SEC_CYN_BLU: begin
        g_comp = xn3_r;
        b_comp = cn3_r;
      end
      SEC_BLU_MAG: begin
        r_comp = xn3_r;
        b_comp = cn3_r;
      end
      SEC_MAG_RED: begin
        r_comp = cn3_r;
        b_comp = xn3_r;
      end
      default: begin
        r_comp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_red_r   <= r_comp + mn3_r;
      n_green_r <= g_comp + mn3_r;
      n_blue_r  <= b_comp + mn3_r;
    end
  end

  // stages 5 and 6: scale, round and clamp each channel
  hsl_chan_scale u_scale_red (
    .clk  (clk),
    .en   (en),
    .num  (n_red_r),
    .chan (out_red)
  );

  hsl_chan_scale u_scale_green (
    .clk  (clk),
    .en   (en),
    .num  (n_green_r),
    .chan (out_green)
  );

  hsl_chan_scale u_scale_blue (
    .clk  (clk),
    .en   (en),
    .num  (n_blue_r),
    .chan (out_blue)
  );

  assign out_valid = v6_r;

`ifndef SYNTH
  // the input is held off only while a finished result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // chroma never exceeds one
  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (c2_r <= ONE_Q24))
    else $error("chroma out of range");

  // secondary weight stays within one sector
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (w1_r <= SECTOR_W12))
    else $error("secondary weight out of range");

  // gray hue gives three equal channel numerators
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r && sec3_r == SEC_GRAY) |=>
      (n_red_r == n_green_r && n_green_r == n_blue_r))
    else $error("gray pixel with unequal channels");
`endif

endmodule

FILE: tb/tb.sv
// self-checking testbench for the hsl to rgb converter: random traffic, stalls, exact color check
module tb;
  import hsl_pkg::*;

  // exact-arithmetic constants, every channel held as a numerator over CHAN_DEN
  localparam longint UNIT     = longint'(ONE_Q12);
  localparam longint SEC_LEN  = longint'(SECTOR_Q6);
  localparam longint CHAN_DEN = longint'(ONE_Q24) * SEC_LEN;
  localparam longint CHAN_TOP = longint'(CHAN_MAX);

  // random part size and the one long output hold-off
  localparam int RANDOM_PIXELS = 1400;
  localparam int HOLD_START    = 300;
  localparam int HOLD_LEN      = 150;
  localparam int DRAIN_CYCLES  = 12;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] light;
  } hsl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue_q6 = '0;
  logic [FRAC_W-1:0] in_sat_q12 = '0;
  logic [FRAC_W-1:0] in_light_q12 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  hsl_t pixel_queue[$];
  rgb_t rgb_expected[$];
  hsl_t next_px;

  int   pixels_total = 0;
  int   pixels_taken = 0;
  int   colors_seen = 0;
  int   gray_taken = 0;
  int   clipped_taken = 0;
  int   backpressure_cycles = 0;
  int   error_count = 0;
  logic in_xfer = 1'b0;

  // sender burst and gap state
  int   burst_left = 0;
  int   gap_left = 0;

  // receiver stall pattern state
  int   cyc = 0;
  int   seg_left = 0;
  int   seg_mode = 0;

  hsl_to_rgb dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue_q6    (in_hue_q6),
    .in_sat_q12   (in_sat_q12),
    .in_light_q12 (in_light_q12),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always #5 clk = ~clk;

  // scale one channel numerator to 0..255, round half up, clamp
  function automatic logic [CHAN_W-1:0] chan_byte(longint num);
    longint v;
    if (num < 0) return '0;
    v = (num * CHAN_TOP + CHAN_DEN / 2) / CHAN_DEN;
    if (v > CHAN_TOP) v = CHAN_TOP;
    return v[CHAN_W-1:0];
  endfunction

  // expected color for one pixel
  function automatic rgb_t convert_pixel(hsl_t px);
    longint  sat, light, dev, span, chroma, phase, wgt;
    longint  c_num, x_num, m_num, r, g, b;
    sector_t sec;
    rgb_t    res;
    sat   = (px.sat > ONE_Q12) ? UNIT : longint'(px.sat);
    light = (px.light > ONE_Q12) ? UNIT : longint'(px.light);
    dev = 2 * light - UNIT;
    if (dev < 0) dev = -dev;
    span   = UNIT - dev;
    chroma = span * sat;
    // secondary weight from the position inside a pair of sectors
    phase = longint'(px.hue) % (2 * SEC_LEN);
    wgt = phase - SEC_LEN;
    if (wgt < 0) wgt = -wgt;
    wgt = SEC_LEN - wgt;
    c_num = chroma * SEC_LEN;
    x_num = chroma * wgt;
    m_num = light * UNIT * SEC_LEN - chroma * (SEC_LEN / 2);
    r = 0;
    g = 0;
    b = 0;
    if (px.hue >= FULL_TURN_Q6) sec = SEC_GRAY;
    else sec = sector_t'(3'(px.hue / SECTOR_Q6));
    case (sec)
      SEC_RED_YEL: begin r = c_num; g = x_num; end
      SEC_YEL_GRN: begin r = x_num; g = c_num; end
      SEC_GRN_CYN: begin g = c_num; b = x_num; end
      SEC_CYN_BLU: begin g = x_num; b = c_num; end
      SEC_BLU_MAG: begin r = x_num; b = c_num; end
      SEC_MAG_RED: begin r = c_num; b = x_num; end
      default: begin end
    endcase
    res.red   = chan_byte(r + m_num);
    res.green = chan_byte(g + m_num);
    res.blue  = chan_byte(b + m_num);
    return res;
  endfunction

  task automatic add_pixel(int hue, int sat, int light);
    hsl_t px;
    px.hue   = hue[HUE_W-1:0];
    px.sat   = sat[FRAC_W-1:0];
    px.light = light[FRAC_W-1:0];
    pixel_queue = {pixel_queue, px};
    pixels_total++;
  endtask

  // field value with extremes and out-of-range values mixed in
  function automatic int pick_frac();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return $urandom_range(0, 8191);
      1: return 4096;
      2: return 0;
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  // stimulus: directed corners, then random pixels
  initial begin
    int hue;
    // sector boundaries at full saturation, mid lightness
    add_pixel(0, 4096, 2048);
    add_pixel(3839, 4096, 2048);
    add_pixel(3840, 4096, 2048);
    add_pixel(7680, 4096, 2048);
    add_pixel(11520, 4096, 2048);
    add_pixel(15360, 4096, 2048);
    add_pixel(19200, 4096, 2048);
    add_pixel(23039, 4096, 2048);
    // hue at or past a full turn gives gray
    add_pixel(23040, 4096, 2048);
    add_pixel(26000, 4096, 1000);
    add_pixel(32767, 8191, 8191);
    // zero saturation, black, white, mid sector
    add_pixel(1920, 4096, 1024);
    add_pixel(5000, 0, 3000);
    add_pixel(9000, 4096, 0);
    add_pixel(13000, 4096, 4096);
    add_pixel(0, 0, 0);
    // saturation or lightness above one
    add_pixel(17000, 8191, 1500);
    add_pixel(21000, 2000, 8191);
    add_pixel(7679, 4097, 4097);
    // tiny and near-half values
    add_pixel(3000, 1, 1);
    add_pixel(1, 4095, 2047);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ($urandom_range(0, 9) == 0) hue = $urandom_range(0, 32767);
      else hue = $urandom_range(0, 23039);
      add_pixel(hue, pick_frac(), pick_frac());
    end

    // reset, then run until every pixel is taken and every color has come back
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (pixels_taken < pixels_total) @(negedge clk);
    while (rgb_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb: %0d pixels converted, %0d past a full turn, %0d with clipped inputs",
             colors_seen, gray_taken, clipped_taken);
    $display("tb: input held off by the block on %0d cycles", backpressure_cycles);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // driver: bursts of pixels with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_queue.size() != 0) begin
        next_px = pixel_queue.pop_front();
        in_hue_q6    <= next_px.hue;
        in_sat_q12   <= next_px.sat;
        in_light_q12 <= next_px.light;
        in_valid     <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall segments of random density, plus one long hold-off
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode <= $urandom_range(0, 3);
        seg_left <= $urandom_range(5, 60);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // monitor: check each result transfer, then record each input transfer
  always @(posedge clk) begin
    rgb_t exp_rgb;
    hsl_t px;
    in_xfer <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      colors_seen++;
      if (rgb_expected.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        error_count++;
      end else begin
        exp_rgb = rgb_expected.pop_front();
        if (out_red !== exp_rgb.red) begin
          $error("red: expected %0d, actual %0d", exp_rgb.red, out_red);
          error_count++;
        end
        if (out_green !== exp_rgb.green) begin
          $error("green: expected %0d, actual %0d", exp_rgb.green, out_green);
          error_count++;
        end
        if (out_blue !== exp_rgb.blue) begin
          $error("blue: expected %0d, actual %0d", exp_rgb.blue, out_blue);
          error_count++;
        end
      end
    end
    if (rst_n && in_valid && in_stall) backpressure_cycles++;
    if (rst_n && in_valid && !in_stall) begin
      px.hue   = in_hue_q6;
      px.sat   = in_sat_q12;
      px.light = in_light_q12;
      rgb_expected = {rgb_expected, convert_pixel(px)};
      pixels_taken++;
      if (px.hue >= FULL_TURN_Q6) gray_taken++;
      if (px.sat > ONE_Q12 || px.light > ONE_Q12) clipped_taken++;
    end
  end

endmodule
